// ===== rtl/led_pixel_pwm_code_encoder_defines.svh =====
// Assertion macros for the encoder checker.
`ifndef LED_PIXEL_PWM_CODE_ENCODER_DEFINES_SVH
`define LED_PIXEL_PWM_CODE_ENCODER_DEFINES_SVH

// Check that is switched off while reset is asserted.
`define LPPCE_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("lppce check failed");

// Check that also runs during reset.
`define LPPCE_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("lppce check failed");

`endif

// ===== rtl/lppce_pkg.sv =====
package lppce_pkg;

    localparam int COLOR_W      = 8;
    localparam int PROD_W       = 16;
    localparam int CODE_W       = 10;
    localparam int WORD_W       = 3 * COLOR_W;
    localparam int BITS_PER_LED = 24;
    localparam int CNT_W        = 5;
    localparam int APB_DATA_W   = 32;
    localparam int APB_ADDR_W   = 3;

    localparam logic [CODE_W-1:0] ONE_CODE_RST  = 10'd183;
    localparam logic [CODE_W-1:0] ZERO_CODE_RST = 10'd83;
    localparam logic [PROD_W-1:0] ROUND_BIAS    = 16'd127;
    localparam logic [PROD_W-1:0] DIV_BASE      = 16'd255;

    // Register map, selected by paddr[2]
    typedef enum logic {
        REG_ONE_CODE  = 1'b0,
        REG_ZERO_CODE = 1'b1
    } t_lppce_reg;

    // Load enables of the scaling stages
    typedef struct packed {
        logic ld2;
        logic ld3;
        logic ld4;
    } t_lppce_adv;

endpackage

// ===== rtl/lppce_scaler.sv =====
module lppce_scaler (
    input  logic                          i_clk,
    input  lppce_pkg::t_lppce_adv         i_adv,
    input  logic [lppce_pkg::COLOR_W-1:0] i_level,
    input  logic [lppce_pkg::COLOR_W-1:0] i_bright,
    output logic [lppce_pkg::COLOR_W-1:0] o_scaled
);
    import lppce_pkg::*;

    logic [PROD_W-1:0]  r_prod2;
    logic [PROD_W-1:0]  r_prod3;
    logic [COLOR_W-1:0] r_quot3;
    logic [COLOR_W-1:0] r_quot4;
    logic [PROD_W-1:0]  n_sum;
    logic [PROD_W-1:0]  n_back;
    logic [PROD_W-1:0]  n_rem;

    // Stage 2: rounded product c*b + 127
    always_ff @(posedge i_clk) begin
        if (i_adv.ld2) begin
            r_prod2 <= (PROD_W'(i_level) * PROD_W'(i_bright)) + ROUND_BIAS;
        end
    end

    // Stage 3: quotient estimate p*257/65536, low by at most one
    assign n_sum = r_prod2 + {{COLOR_W{1'b0}}, r_prod2[PROD_W-1:COLOR_W]};

    always_ff @(posedge i_clk) begin
        if (i_adv.ld3) begin
            r_prod3 <= r_prod2;
            r_quot3 <= n_sum[PROD_W-1:COLOR_W];
        end
    end

    // Stage 4: remainder check and correction
    assign n_back = {r_quot3, {COLOR_W{1'b0}}} - {{COLOR_W{1'b0}}, r_quot3};
    assign n_rem  = r_prod3 - n_back;

    always_ff @(posedge i_clk) begin
        if (i_adv.ld4) begin
            if (n_rem >= DIV_BASE) begin
                r_quot4 <= COLOR_W'(r_quot3 + 1'b1);
            end else begin
                r_quot4 <= r_quot3;
            end
        end
    end

    assign o_scaled = r_quot4;

endmodule

// ===== rtl/led_pixel_pwm_code_encoder.sv =====
// LED pixel PWM code encoder.
// Input channel (i_in_valid / o_in_ready): one LED per transaction, with red,
// green and blue levels, a brightness and a last-LED-of-frame flag.
// Each color is scaled to round(c*brightness/255) in a four-stage pipeline
// (input register, multiply, quotient estimate, remainder correction).
// Output channel (o_out_valid / i_out_ready): 24 compare codes per LED, MSB
// of {red, green, blue} first; o_led_done marks the 24th code and
// o_frame_done marks the 24th code of the frame's last LED.
// An LED's first code passes the input, multiply, quotient and correction
// registers, then the code register. Throughput: one code per cycle while the
// receiver is ready, set by the single output serializer; the next LED's first
// code follows the previous LED's last code with no gap.
// Up to four further LEDs wait in the pipeline while the serializer works.
// A stalled receiver holds the current code; the pipeline fills and then
// o_in_ready drops. Nothing is lost or repeated.
// Reset (synchronous, active low) empties the pipeline and serializer and
// loads the code registers with 183 (one bit) and 83 (zero bit).
// APB: offset 0x0 one-bit code, 0x4 zero-bit code; write only when idle.
module led_pixel_pwm_code_encoder (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // input channel
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [lppce_pkg::COLOR_W-1:0]    i_red_level,
    input  logic [lppce_pkg::COLOR_W-1:0]    i_green_level,
    input  logic [lppce_pkg::COLOR_W-1:0]    i_blue_level,
    input  logic [lppce_pkg::COLOR_W-1:0]    i_led_brightness,
    input  logic                             i_frame_last_led,
    // output channel
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [lppce_pkg::CODE_W-1:0]     o_compare_code,
    output logic                             o_led_done,
    output logic                             o_frame_done,
    // configuration port
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [lppce_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [lppce_pkg::APB_DATA_W-1:0] pwdata,
    output logic [lppce_pkg::APB_DATA_W-1:0] prdata,
    output logic                             pready
);
    import lppce_pkg::*;

    localparam logic [CNT_W-1:0] LAST_BIT = CNT_W'(BITS_PER_LED - 1);

    logic [CODE_W-1:0]  r_one_code;
    logic [CODE_W-1:0]  r_zero_code;
    t_lppce_reg         n_reg_sel;
    logic               n_cfg_wr;

    logic               r_v1, r_v2, r_v3, r_v4;
    logic [COLOR_W-1:0] r_s1_red, r_s1_green, r_s1_blue, r_s1_bright;
    logic               r_s1_last, r_s2_last, r_s3_last, r_s4_last;
    logic               n_en1, n_en2, n_en3, n_en4;
    t_lppce_adv         n_adv;
    logic [COLOR_W-1:0] n_red_q, n_green_q, n_blue_q;
    logic [WORD_W-1:0]  n_word;

    logic               r_out_valid;
    logic [WORD_W-1:0]  r_word;
    logic [CNT_W-1:0]   r_cnt;
    logic [CODE_W-1:0]  r_code;
    logic               r_led_done;
    logic               r_frame;
    logic               n_ser_take;

    // APB register file
    assign pready    = 1'b1;
    assign n_reg_sel = t_lppce_reg'(paddr[2]);
    assign n_cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_one_code  <= ONE_CODE_RST;
            r_zero_code <= ZERO_CODE_RST;
        end else if (n_cfg_wr) begin
            unique case (n_reg_sel)
                REG_ONE_CODE:  r_one_code  <= pwdata[CODE_W-1:0];
                REG_ZERO_CODE: r_zero_code <= pwdata[CODE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (n_reg_sel)
            REG_ONE_CODE:  prdata = APB_DATA_W'(r_one_code);
            REG_ZERO_CODE: prdata = APB_DATA_W'(r_zero_code);
            default:       prdata = '0;
        endcase
    end

    // Stall chain: each stage moves when the one after it can take data
    assign n_ser_take = !r_out_valid || (i_out_ready && r_led_done);
    assign n_en4      = !r_v4 || n_ser_take;
    assign n_en3      = !r_v3 || n_en4;
    assign n_en2      = !r_v2 || n_en3;
    assign n_en1      = !r_v1 || n_en2;
    assign o_in_ready = n_en1;

    assign n_adv.ld2 = n_en2 && r_v1;
    assign n_adv.ld3 = n_en3 && r_v2;
    assign n_adv.ld4 = n_en4 && r_v3;

    // Pipeline valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (n_en1) r_v1 <= i_in_valid;
            if (n_en2) r_v2 <= r_v1;
            if (n_en3) r_v3 <= r_v2;
            if (n_en4) r_v4 <= r_v3;
        end
    end

    // Stage 1: input register
    always_ff @(posedge i_clk) begin
        if (n_en1 && i_in_valid) begin
            r_s1_red    <= i_red_level;
            r_s1_green  <= i_green_level;
            r_s1_blue   <= i_blue_level;
            r_s1_bright <= i_led_brightness;
            r_s1_last   <= i_frame_last_led;
        end
    end

    // Frame flag travels alongside the scaled colors
    always_ff @(posedge i_clk) begin
        if (n_adv.ld2) r_s2_last <= r_s1_last;
        if (n_adv.ld3) r_s3_last <= r_s2_last;
        if (n_adv.ld4) r_s4_last <= r_s3_last;
    end

    lppce_scaler u_scale_red (
        .i_clk    (i_clk),
        .i_adv    (n_adv),
        .i_level  (r_s1_red),
        .i_bright (r_s1_bright),
        .o_scaled (n_red_q)
    );

    lppce_scaler u_scale_green (
        .i_clk    (i_clk),
        .i_adv    (n_adv),
        .i_level  (r_s1_green),
        .i_bright (r_s1_bright),
        .o_scaled (n_green_q)
    );

    lppce_scaler u_scale_blue (
        .i_clk    (i_clk),
        .i_adv    (n_adv),
        .i_level  (r_s1_blue),
        .i_bright (r_s1_bright),
        .o_scaled (n_blue_q)
    );

    assign n_word = {n_red_q, n_green_q, n_blue_q};

    // Output serializer: one code per output transaction, MSB first
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
            r_led_done  <= 1'b0;
        end else if (n_ser_take) begin
            r_out_valid <= r_v4;
            if (r_v4) begin
                r_word     <= {n_word[WORD_W-2:0], 1'b0};
                r_code     <= n_word[WORD_W-1] ? r_one_code : r_zero_code;
                r_cnt      <= '0;
                r_led_done <= 1'b0;
                r_frame    <= r_s4_last;
            end
        end else if (i_out_ready) begin
            r_word     <= {r_word[WORD_W-2:0], 1'b0};
            r_code     <= r_word[WORD_W-1] ? r_one_code : r_zero_code;
            r_cnt      <= CNT_W'(r_cnt + 1'b1);
            r_led_done <= (CNT_W'(r_cnt + 1'b1) == LAST_BIT);
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_compare_code = r_code;
    assign o_led_done     = r_led_done;
    assign o_frame_done   = r_led_done && r_frame;

endmodule

// ===== rtl/lppce_checker.sv =====
`include "led_pixel_pwm_code_encoder_defines.svh"

module lppce_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             o_out_valid,
    input  logic                             i_out_ready,
    input  logic [lppce_pkg::CODE_W-1:0]     o_compare_code,
    input  logic                             o_led_done,
    input  logic                             o_frame_done
);

    // Stalled code keeps its value and its LED-done mark
    property p_out_hold;
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_compare_code) && $stable(o_led_done);
    endproperty

    // Reset leaves no code on the output
    `LPPCE_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !o_out_valid)

    // End of frame only comes with end of LED
    `LPPCE_ASSERT(a_frame_on_led, i_clk, i_rst_n, o_out_valid && o_frame_done |-> o_led_done)

    // Codes of one LED come back to back
    `LPPCE_ASSERT(a_led_burst, i_clk, i_rst_n, o_out_valid && i_out_ready && !o_led_done |=> o_out_valid)

    // Stalled code holds
    `LPPCE_ASSERT(a_out_hold, i_clk, i_rst_n, p_out_hold)

endmodule

bind led_pixel_pwm_code_encoder lppce_checker u_lppce_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .o_compare_code (o_compare_code),
    .o_led_done     (o_led_done),
    .o_frame_done   (o_frame_done)
);

// ===== tb/led_code_checker.sv =====
`timescale 1ns / 1ps

// Watches both channels and the APB port of the LED code encoder, predicts the
// 24 compare codes of every accepted LED and compares them with the codes that
// leave the block.
module led_code_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // input channel
    input  logic                             i_in_valid,
    input  logic                             i_in_ready,
    input  logic [lppce_pkg::COLOR_W-1:0]    i_red_level,
    input  logic [lppce_pkg::COLOR_W-1:0]    i_green_level,
    input  logic [lppce_pkg::COLOR_W-1:0]    i_blue_level,
    input  logic [lppce_pkg::COLOR_W-1:0]    i_led_brightness,
    input  logic                             i_frame_last_led,
    // output channel
    input  logic                             i_out_valid,
    input  logic                             i_out_ready,
    input  logic [lppce_pkg::CODE_W-1:0]     i_compare_code,
    input  logic                             i_led_done,
    input  logic                             i_frame_done,
    // configuration port
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [lppce_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [lppce_pkg::APB_DATA_W-1:0] pwdata,
    input  logic [lppce_pkg::APB_DATA_W-1:0] prdata,
    input  logic                             pready,
    // status to the testbench top
    output int                               o_fail_count,
    output int                               o_pending,
    output int                               o_leds,
    output int                               o_codes,
    output int                               o_frames
);
    import lppce_pkg::*;

    localparam int PRINT_CAP = 100;

    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic              led_done;
        logic              frame_done;
    } t_bit_code;

    t_bit_code         expected_codes[$];
    logic [CODE_W-1:0] one_code;
    logic [CODE_W-1:0] zero_code;
    int                fail_cnt  = 0;
    int                led_cnt   = 0;
    int                code_cnt  = 0;
    int                frame_cnt = 0;
    int                pending_cnt = 0;

    assign o_fail_count = fail_cnt;
    assign o_pending    = pending_cnt;
    assign o_leds       = led_cnt;
    assign o_codes      = code_cnt;
    assign o_frames     = frame_cnt;

    // One line per mismatch; a flood from a broken block is counted quietly
    task automatic report_mismatch(input string msg);
        if (fail_cnt < PRINT_CAP) begin
            $display("ERROR %0t: %s", $time, msg);
        end else if (fail_cnt == PRINT_CAP) begin
            $display("ERROR %0t: further mismatches are counted only", $time);
        end
        fail_cnt++;
    endtask

    // round(level * bright / 255) in integer form
    function automatic logic [COLOR_W-1:0] scale_color(input logic [COLOR_W-1:0] level,
                                                       input logic [COLOR_W-1:0] bright);
        logic [PROD_W-1:0] prod;
        prod = PROD_W'(level) * PROD_W'(bright);
        prod = prod + 16'd127;
        return COLOR_W'(prod / 16'd255);
    endfunction

    // Queue the 24 codes of one LED, MSB of {red, green, blue} first
    task automatic predict_led_codes();
        logic [WORD_W-1:0] word;
        t_bit_code         item;
        word = {scale_color(i_red_level, i_led_brightness),
                scale_color(i_green_level, i_led_brightness),
                scale_color(i_blue_level, i_led_brightness)};
        for (int k = 0; k < BITS_PER_LED; k++) begin
            item.code       = word[WORD_W-1-k] ? one_code : zero_code;
            item.led_done   = (k == BITS_PER_LED - 1);
            item.frame_done = (k == BITS_PER_LED - 1) && i_frame_last_led;
            expected_codes.push_back(item);
        end
        led_cnt++;
    endtask

    // Compare one accepted code with the oldest expectation
    task automatic check_code();
        t_bit_code want;
        if (expected_codes.size() == 0) begin
            report_mismatch($sformatf("code %0d arrived with nothing expected",
                                      i_compare_code));
        end else begin
            want = expected_codes.pop_front();
            if (i_compare_code !== want.code)
                report_mismatch($sformatf("code #%0d compare_code %0d, expected %0d",
                                          code_cnt, i_compare_code, want.code));
            if (i_led_done !== want.led_done)
                report_mismatch($sformatf("code #%0d led_done %0b, expected %0b",
                                          code_cnt, i_led_done, want.led_done));
            if (i_frame_done !== want.frame_done)
                report_mismatch($sformatf("code #%0d frame_done %0b, expected %0b",
                                          code_cnt, i_frame_done, want.frame_done));
            if (want.frame_done)
                frame_cnt++;
        end
        code_cnt++;
    endtask

    // Register copy, prediction and comparison, all on sampled values
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            one_code  = ONE_CODE_RST;
            zero_code = ZERO_CODE_RST;
            expected_codes.delete();
        end else begin
            // APB access phase
            if (psel && penable && pready) begin
                if (pwrite) begin
                    case (t_lppce_reg'(paddr[2]))
                        REG_ONE_CODE:  one_code  = pwdata[CODE_W-1:0];
                        REG_ZERO_CODE: zero_code = pwdata[CODE_W-1:0];
                    endcase
                end else begin
                    logic [APB_DATA_W-1:0] want_rd;
                    want_rd = (t_lppce_reg'(paddr[2]) == REG_ONE_CODE) ?
                              APB_DATA_W'(one_code) : APB_DATA_W'(zero_code);
                    if (prdata !== want_rd)
                        report_mismatch($sformatf("read of 0x%0h gave 0x%0h, expected 0x%0h",
                                                  paddr, prdata, want_rd));
                end
            end
            if (i_in_valid && i_in_ready)
                predict_led_codes();
            if (i_out_valid && i_out_ready)
                check_code();
        end
        pending_cnt = expected_codes.size();
    end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import lppce_pkg::*;

    localparam int RESET_CYCLES = 10;
    localparam int RANDOM_LEDS  = 156;
    localparam int PHASES       = 6;
    localparam int HOLD_CYCLES  = 400;
    localparam int SETTLE       = 8;
    localparam int CYCLE_LIMIT  = 500000;

    logic                  i_clk            = 1'b0;
    logic                  i_rst_n          = 1'b0;
    logic                  i_in_valid       = 1'b0;
    logic [COLOR_W-1:0]    i_red_level      = '0;
    logic [COLOR_W-1:0]    i_green_level    = '0;
    logic [COLOR_W-1:0]    i_blue_level     = '0;
    logic [COLOR_W-1:0]    i_led_brightness = '0;
    logic                  i_frame_last_led = 1'b0;
    logic                  i_out_ready      = 1'b0;
    logic                  psel             = 1'b0;
    logic                  penable          = 1'b0;
    logic                  pwrite           = 1'b0;
    logic [APB_ADDR_W-1:0] paddr            = '0;
    logic [APB_DATA_W-1:0] pwdata           = '0;

    logic                  o_in_ready;
    logic                  o_out_valid;
    logic [CODE_W-1:0]     o_compare_code;
    logic                  o_led_done;
    logic                  o_frame_done;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    int fail_count;
    int pending;
    int leds_seen;
    int codes_seen;
    int frames_seen;

    int cycle_cnt    = 0;
    int settings_cnt = 1;
    int hold_cnt     = 0;
    bit valid_mirror = 1'b0;
    int burst_left   = 0;
    int max_gap      = 0;
    int rx_mode      = 0;
    bit hold_req     = 1'b0;

    led_pixel_pwm_code_encoder dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_red_level      (i_red_level),
        .i_green_level    (i_green_level),
        .i_blue_level     (i_blue_level),
        .i_led_brightness (i_led_brightness),
        .i_frame_last_led (i_frame_last_led),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_compare_code   (o_compare_code),
        .o_led_done       (o_led_done),
        .o_frame_done     (o_frame_done),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    led_code_checker u_code_check (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .i_in_ready       (o_in_ready),
        .i_red_level      (i_red_level),
        .i_green_level    (i_green_level),
        .i_blue_level     (i_blue_level),
        .i_led_brightness (i_led_brightness),
        .i_frame_last_led (i_frame_last_led),
        .i_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .i_compare_code   (o_compare_code),
        .i_led_done       (o_led_done),
        .i_frame_done     (o_frame_done),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .o_fail_count     (fail_count),
        .o_pending        (pending),
        .o_leds           (leds_seen),
        .o_codes          (codes_seen),
        .o_frames         (frames_seen)
    );

    // 20 ns clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Cycle limit
    initial begin
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("timeout after %0d cycles, %0d codes still expected", cycle_cnt, pending);
        $display("led_pixel_pwm_code_encoder test failed");
        $finish;
    end

    // Receiver: runs of ready and stall, plus an occasional long hold-off
    initial begin : rx_pattern
        int run;
        bit rdy;
        @(posedge i_clk);
        forever begin
            if (hold_req) begin
                i_out_ready <= 1'b0;
                run = HOLD_CYCLES;
                hold_req = 1'b0;
                hold_cnt++;
            end else if (rx_mode == 0) begin
                i_out_ready <= 1'b1;
                run = $urandom_range(1, 16);
            end else begin
                rdy = (rx_mode == 1) ? ($urandom_range(0, 3) != 0) :
                                       1'($urandom_range(0, 1));
                i_out_ready <= rdy;
                run = rdy ? $urandom_range(1, 6) : $urandom_range(1, (rx_mode == 1) ? 3 : 8);
            end
            repeat (run) @(posedge i_clk);
        end
    end

    // Keeps one nonblocking write of valid per time step
    task automatic set_valid(input bit v);
        if (v != valid_mirror) begin
            i_in_valid <= v;
            valid_mirror = v;
        end
    endtask

    // Offer one LED and wait for its transaction; bursts end in random gaps
    task automatic send_led(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                            input logic [7:0] br, input logic last);
        int gap;
        i_red_level      <= r;
        i_green_level    <= g;
        i_blue_level     <= b;
        i_led_brightness <= br;
        i_frame_last_led <= last;
        set_valid(1'b1);
        do @(posedge i_clk); while (!o_in_ready);
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 8);
            gap = $urandom_range(0, max_gap);
            if (gap > 0) begin
                set_valid(1'b0);
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    // Random LED, brightness weighted toward its extremes
    task automatic send_random_led(input logic last);
        logic [7:0] br;
        case ($urandom_range(0, 7))
            0:       br = 8'd0;
            1:       br = 8'd255;
            default: br = 8'($urandom_range(0, 255));
        endcase
        send_led(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                 8'($urandom_range(0, 255)), br, last);
    endtask

    // Mostly whole frames closed by a last-LED flag, some stray LEDs
    task automatic send_random_frames(input int count);
        int sent;
        int len;
        sent = 0;
        while (sent < count) begin
            if ($urandom_range(0, 4) == 0) begin
                send_random_led(1'($urandom_range(0, 1)));
                sent++;
            end else begin
                len = $urandom_range(1, 6);
                if (len > count - sent)
                    len = count - sent;
                for (int k = 0; k < len; k++)
                    send_random_led(k == len - 1);
                sent += len;
            end
        end
    endtask

    // Stop sending and wait until every expected code has come out
    task automatic drain_all();
        set_valid(1'b0);
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // APB transaction: setup then access, done when pready is high
    task automatic apb_access(input bit wr, input t_lppce_reg r, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {r, 2'b00};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // Write both codes, then read them back
    task automatic set_codes(input logic [31:0] one_val, input logic [31:0] zero_val);
        apb_access(1'b1, REG_ONE_CODE, one_val);
        apb_access(1'b1, REG_ZERO_CODE, zero_val);
        apb_access(1'b0, REG_ONE_CODE, '0);
        apb_access(1'b0, REG_ZERO_CODE, '0);
        settings_cnt++;
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed LEDs under the reset codes
        max_gap = 3;
        rx_mode = 1;
        apb_access(1'b0, REG_ONE_CODE, '0);
        apb_access(1'b0, REG_ZERO_CODE, '0);
        send_led(8'd0,   8'd0,   8'd0,   8'd255, 1'b0);
        send_led(8'd255, 8'd255, 8'd255, 8'd255, 1'b0);
        // zero brightness blanks every color
        send_led(8'd255, 8'd255, 8'd255, 8'd0,   1'b1);
        send_led(8'd170, 8'd85,  8'd170, 8'd255, 1'b0);
        send_led(8'd85,  8'd170, 8'd85,  8'd255, 1'b1);
        // rounding edges at brightness 1 and 127/128
        send_led(8'd128, 8'd1,   8'd128, 8'd1,   1'b0);
        send_led(8'd255, 8'd127, 8'd128, 8'd1,   1'b0);
        send_led(8'd1,   8'd1,   8'd1,   8'd128, 1'b0);
        send_led(8'd1,   8'd1,   8'd1,   8'd127, 1'b1);
        send_led(8'd128, 8'd64,  8'd200, 8'd128, 1'b0);
        send_led(8'd255, 8'd0,   8'd0,   8'd255, 1'b0);
        send_led(8'd0,   8'd255, 8'd0,   8'd255, 1'b0);
        send_led(8'd0,   8'd0,   8'd255, 8'd255, 1'b1);
        send_led(8'd200, 8'd100, 8'd50,  8'd77,  1'b0);
        drain_all();

        // Extreme codes; upper data bits must be dropped
        set_codes(32'hFFFF_FFFF, 32'hFFFF_FC00);
        send_led(8'd170, 8'd85,  8'd170, 8'd255, 1'b0);
        send_led(8'd255, 8'd255, 8'd255, 8'd255, 1'b1);
        send_led(8'd0,   8'd0,   8'd0,   8'd255, 1'b0);
        send_led(8'd85,  8'd170, 8'd85,  8'd255, 1'b1);
        drain_all();
        set_codes(32'h0000_0000, 32'h55AA_03FF);
        send_led(8'd170, 8'd85,  8'd170, 8'd255, 1'b0);
        send_led(8'd255, 8'd0,   8'd255, 8'd255, 1'b0);
        send_led(8'd12,  8'd200, 8'd99,  8'd255, 1'b1);
        send_led(8'd255, 8'd255, 8'd255, 8'd0,   1'b1);
        drain_all();

        // Random phases, each under its own codes and idling pattern
        for (int p = 0; p < PHASES; p++) begin
            if (p == PHASES - 1)
                set_codes(32'(ONE_CODE_RST), 32'(ZERO_CODE_RST));
            else
                set_codes($urandom, $urandom);
            rx_mode = p % 3;
            max_gap = (p % 2) ? 20 : 4;
            if (p == 3) begin
                // receiver holds off while the sender keeps offering
                max_gap  = 0;
                hold_req = 1'b1;
            end
            send_random_frames(RANDOM_LEDS / PHASES);
            drain_all();
        end

        $display("Sent %0d LEDs (%0d frame ends), checked %0d codes", leds_seen,
                 frames_seen, codes_seen);
        $display("Ran %0d code settings and %0d long receiver hold-offs", settings_cnt,
                 hold_cnt);
        if (fail_count == 0 && pending == 0) begin
            $display("led_pixel_pwm_code_encoder test passed");
        end else begin
            $display("led_pixel_pwm_code_encoder test failed");
        end
        $finish;
    end

endmodule

// ===== led_pixel_pwm_code_encoder.f =====
+incdir+rtl
rtl/lppce_pkg.sv
rtl/lppce_scaler.sv
rtl/led_pixel_pwm_code_encoder.sv
rtl/lppce_checker.sv
tb/led_code_checker.sv
tb/testbench.sv
